// File: hw/rtl/centered_window_adaptive_threshold_assert.svh
// Assertion helpers for the window threshold block.
`ifndef CENTERED_WINDOW_ADAPTIVE_THRESHOLD_ASSERT_SVH
`define CENTERED_WINDOW_ADAPTIVE_THRESHOLD_ASSERT_SVH

// Check a consequence in the same cycle as its cause.
`define CWAT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define CWAT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/cwat_pkg.sv
package cwat_pkg;

  localparam int unsigned FRAME_W   = 24;
  localparam int unsigned DIST_W    = 16;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned FRAC_W    = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_STATIC_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAN_GAIN  = 2'd1;

  localparam logic [CFG_W-1:0] STATIC_THR_RST = 16'd2048;
  localparam logic [CFG_W-1:0] MEAN_GAIN_RST  = 16'd3277;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
  } q_status_t;

  typedef struct packed {
    logic [CFG_W-1:0] static_thr;
    logic [CFG_W-1:0] mean_gain;
  } cfg_t;

endpackage

// File: hw/rtl/centered_window_adaptive_threshold.sv
// Channel   Direction  Handshake            Beat
// in        sink       in_valid_i/stall_o   frame_number, distance, end_of_sequence
// out       source     out_valid_o/stall_i  decided_frame, is_candidate, final_decision
// cfg       sink       cfg_valid_i/ready_o  cfg_index, cfg_data (16 bit)
//
// One input beat per cycle unless in_stall_o is high; a decision passes the store read, job
// queue, multiply and output registers. An end-of-sequence beat holds the input while the flush
// sequencer issues one pending decision a cycle, if the queue has room, via the store reads.
// A full output stage backs up the four-entry job queue, which then stalls the input.
// Reset clears pointers, counts and the running sum; the sample store is not cleared.
module centered_window_adaptive_threshold #(
  parameter int unsigned WINDOW = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [cwat_pkg::FRAME_W-1:0]         frame_number_i,
  input  logic [cwat_pkg::DIST_W-1:0]          distance_i,
  input  logic                                 end_of_sequence_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [cwat_pkg::FRAME_W-1:0]         decided_frame_o,
  output logic                                 is_candidate_o,
  output logic                                 final_decision_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [cwat_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [cwat_pkg::CFG_W-1:0]           cfg_data_i
);

  `include "centered_window_adaptive_threshold_assert.svh"

  localparam int unsigned DEPTH  = 2 * WINDOW - 1;
  localparam int unsigned SLOT_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W  = cwat_pkg::DIST_W + SLOT_W;
  localparam int unsigned JOB_W  = cwat_pkg::FRAME_W + cwat_pkg::DIST_W + CNT_W + SUM_W + 1;

  cwat_pkg::cfg_t cfg_q;

  logic                         job_valid, job_final, job_pop;
  logic [cwat_pkg::FRAME_W-1:0] job_frame, q_frame;
  logic [cwat_pkg::DIST_W-1:0]  job_dist, q_dist;
  logic [CNT_W-1:0]             job_count, q_count;
  logic [SUM_W-1:0]             job_sum, q_sum;
  logic                         q_final;
  logic [JOB_W-1:0]             q_data;
  cwat_pkg::q_status_t          q_status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.static_thr <= cwat_pkg::STATIC_THR_RST;
      cfg_q.mean_gain  <= cwat_pkg::MEAN_GAIN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        cwat_pkg::CFG_STATIC_THR: cfg_q.static_thr <= cfg_data_i;
        cwat_pkg::CFG_MEAN_GAIN:  cfg_q.mean_gain  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cwat_front #(
    .WINDOW (WINDOW)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .frame_number_i    (frame_number_i),
    .distance_i        (distance_i),
    .end_of_sequence_i (end_of_sequence_i),
    .q_status_i        (q_status),
    .job_valid_o       (job_valid),
    .job_frame_o       (job_frame),
    .job_dist_o        (job_dist),
    .job_count_o       (job_count),
    .job_sum_o         (job_sum),
    .job_final_o       (job_final)
  );

  cwat_queue #(
    .DATA_W (JOB_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (job_valid),
    .push_data_i ({job_frame, job_dist, job_count, job_sum, job_final}),
    .pop_i       (job_pop),
    .pop_data_o  (q_data),
    .status_o    (q_status)
  );

  assign {q_frame, q_dist, q_count, q_sum, q_final} = q_data;

  cwat_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .job_valid_i      (!q_status.empty),
    .job_frame_i      (q_frame),
    .job_dist_i       (q_dist),
    .job_count_i      (q_count),
    .job_sum_i        (q_sum),
    .job_final_i      (q_final),
    .job_pop_o        (job_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .decided_frame_o  (decided_frame_o),
    .is_candidate_o   (is_candidate_o),
    .final_decision_o (final_decision_o)
  );

  `CWAT_ASSERT_NOW(a_no_push_when_full, job_valid, q_status.count != cwat_pkg::QCNT_W'(cwat_pkg::QUEUE_DEPTH), "job pushed into a full queue")
  `CWAT_ASSERT_NOW(a_no_pop_when_empty, job_pop, !q_status.empty, "job popped from an empty queue")
  `CWAT_ASSERT_NEXT(a_eos_holds_input, in_valid_i && !in_stall_o && end_of_sequence_i, in_stall_o, "input not held during flush")

endmodule

// File: hw/rtl/cwat_front.sv
module cwat_front #(
  parameter int unsigned WINDOW = 16,
  localparam int unsigned DEPTH = 2 * WINDOW - 1,
  localparam int unsigned SLOT_W = $clog2(DEPTH),
  localparam int unsigned CNT_W = $clog2(DEPTH + 1),
  localparam int unsigned SUM_W = cwat_pkg::DIST_W + SLOT_W
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [cwat_pkg::FRAME_W-1:0]   frame_number_i,
  input  logic [cwat_pkg::DIST_W-1:0]    distance_i,
  input  logic                           end_of_sequence_i,
  input  cwat_pkg::q_status_t            q_status_i,
  output logic                           job_valid_o,
  output logic [cwat_pkg::FRAME_W-1:0]   job_frame_o,
  output logic [cwat_pkg::DIST_W-1:0]    job_dist_o,
  output logic [CNT_W-1:0]               job_count_o,
  output logic [SUM_W-1:0]               job_sum_o,
  output logic                           job_final_o
);

  localparam int unsigned EXT_W = SLOT_W + 1;
  localparam int unsigned ENT_W = cwat_pkg::FRAME_W + cwat_pkg::DIST_W;
  localparam int unsigned QC1_W = cwat_pkg::QCNT_W + 1;
  localparam logic [CNT_W-1:0]  DEPTH_C    = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0]  WIN_C      = CNT_W'(WINDOW);
  localparam logic [EXT_W-1:0]  DEPTH_E    = EXT_W'(DEPTH);
  localparam logic [EXT_W-1:0]  DEPTH_M1_E = EXT_W'(DEPTH - 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(DEPTH - 1);
  localparam logic [SLOT_W-1:0] WIN_S      = SLOT_W'(WINDOW);
  localparam logic [SLOT_W-1:0] WIN_M1_S   = SLOT_W'(WINDOW - 1);
  localparam logic [SLOT_W-1:0] WIN_M2_S   = SLOT_W'(WINDOW - 2);

  logic [ENT_W-1:0] store_mem [DEPTH];

  logic [SLOT_W-1:0] ws_q, age_q;
  logic [CNT_W-1:0]  seen_q;
  logic              flush_q;
  logic [SUM_W-1:0]  sum_q;

  logic                        s1_valid_q, s1_emit_q, s1_sub_q, s1_final_q;
  logic [cwat_pkg::DIST_W-1:0] s1_add_q, rd_a_q;
  logic [CNT_W-1:0]            s1_count_q;
  logic [ENT_W-1:0]            rd_b_q;

  logic                        room, accept, flush_go, full, drop;
  logic [CNT_W-1:0]            n_new, count_f_new;
  logic [SLOT_W-1:0]           ws_next, age_plus_w;
  logic                        op_valid, op_emit, op_sub, op_final;
  logic [SLOT_W-1:0]           addr_a, addr_b;
  logic [CNT_W-1:0]            op_count;
  logic [cwat_pkg::DIST_W-1:0] op_add;
  logic [SUM_W-1:0]            sum_d;

  // Slot holding the item of a given age, counted back from the newest.
  function automatic logic [SLOT_W-1:0] slot_of_age(input logic [SLOT_W-1:0] ws,
                                                    input logic [SLOT_W-1:0] age);
    logic [EXT_W-1:0] raw;
    raw = EXT_W'(ws) + DEPTH_M1_E - EXT_W'(age);
    if (raw >= DEPTH_E) begin
      raw = raw - DEPTH_E;
    end
    return raw[SLOT_W-1:0];
  endfunction

  // Leave space in the queue for the job already in flight.
  assign room = ({1'b0, q_status_i.count} + QC1_W'(s1_emit_q))
                < QC1_W'(cwat_pkg::QUEUE_DEPTH);
  assign in_stall_o = flush_q | ~room;
  assign accept     = in_valid_i & ~in_stall_o;
  assign flush_go   = flush_q & room;

  assign full        = (seen_q == DEPTH_C);
  assign n_new       = full ? seen_q : seen_q + CNT_W'(1);
  assign ws_next     = (ws_q == LAST_SLOT) ? '0 : ws_q + SLOT_W'(1);
  assign age_plus_w  = age_q + WIN_S;
  assign drop        = (seen_q > CNT_W'(age_plus_w));
  assign count_f_new = drop ? seen_q - CNT_W'(1) : seen_q;

  always_comb begin
    op_valid = accept | flush_go;
    if (accept) begin
      addr_a   = ws_q;
      op_sub   = full;
      addr_b   = slot_of_age(ws_next, WIN_M1_S);
      op_emit  = (n_new >= WIN_C);
      op_count = n_new;
      op_final = 1'b0;
      op_add   = distance_i;
    end else begin
      // Flush step: shrink the window from below, then decide this age.
      addr_a   = slot_of_age(ws_q, age_plus_w);
      op_sub   = drop;
      addr_b   = slot_of_age(ws_q, age_q);
      op_emit  = 1'b1;
      op_count = count_f_new;
      op_final = (age_q == '0);
      op_add   = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      store_mem[ws_q] <= {frame_number_i, distance_i};
    end
    if (op_valid) begin
      rd_a_q <= store_mem[addr_a][cwat_pkg::DIST_W-1:0];
      rd_b_q <= store_mem[addr_b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_valid) begin
      s1_sub_q   <= op_sub;
      s1_final_q <= op_final;
      s1_count_q <= op_count;
      s1_add_q   <= op_add;
    end
  end

  assign sum_d = sum_q - (s1_sub_q ? SUM_W'(rd_a_q) : '0) + SUM_W'(s1_add_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q       <= '0;
      seen_q     <= '0;
      flush_q    <= 1'b0;
      age_q      <= '0;
      sum_q      <= '0;
      s1_valid_q <= 1'b0;
      s1_emit_q  <= 1'b0;
    end else begin
      s1_valid_q <= op_valid;
      s1_emit_q  <= op_valid & op_emit;
      if (s1_valid_q) begin
        sum_q <= s1_final_q ? '0 : sum_d;
      end
      if (accept) begin
        ws_q   <= ws_next;
        seen_q <= n_new;
        if (end_of_sequence_i) begin
          flush_q <= 1'b1;
          age_q   <= (n_new >= WIN_C) ? WIN_M2_S : SLOT_W'(n_new - CNT_W'(1));
        end
      end else if (flush_go) begin
        if (age_q == '0) begin
          flush_q <= 1'b0;
          ws_q    <= '0;
          seen_q  <= '0;
        end else begin
          age_q  <= age_q - SLOT_W'(1);
          seen_q <= count_f_new;
        end
      end
    end
  end

  assign job_valid_o = s1_emit_q;
  assign job_frame_o = rd_b_q[ENT_W-1:cwat_pkg::DIST_W];
  assign job_dist_o  = rd_b_q[cwat_pkg::DIST_W-1:0];
  assign job_count_o = s1_count_q;
  assign job_sum_o   = sum_d;
  assign job_final_o = s1_final_q;

endmodule

// File: hw/rtl/cwat_queue.sv
module cwat_queue #(
  parameter int unsigned DATA_W = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [DATA_W-1:0]   push_data_i,
  input  logic                pop_i,
  output logic [DATA_W-1:0]   pop_data_o,
  output cwat_pkg::q_status_t status_o
);

  logic [DATA_W-1:0]           entry_q [cwat_pkg::QUEUE_DEPTH];
  logic [cwat_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [cwat_pkg::QCNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + cwat_pkg::QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + cwat_pkg::QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + cwat_pkg::QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - cwat_pkg::QCNT_W'(1);
      end
    end
  end

  assign pop_data_o     = entry_q[rd_ptr_q];
  assign status_o.count = cnt_q;
  assign status_o.empty = (cnt_q == '0);

endmodule

// File: hw/rtl/cwat_back.sv
module cwat_back #(
  parameter int unsigned WINDOW = 16,
  localparam int unsigned DEPTH = 2 * WINDOW - 1,
  localparam int unsigned SLOT_W = $clog2(DEPTH),
  localparam int unsigned CNT_W = $clog2(DEPTH + 1),
  localparam int unsigned SUM_W = cwat_pkg::DIST_W + SLOT_W
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cwat_pkg::cfg_t               cfg_i,
  input  logic                         job_valid_i,
  input  logic [cwat_pkg::FRAME_W-1:0] job_frame_i,
  input  logic [cwat_pkg::DIST_W-1:0]  job_dist_i,
  input  logic [CNT_W-1:0]             job_count_i,
  input  logic [SUM_W-1:0]             job_sum_i,
  input  logic                         job_final_i,
  output logic                         job_pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [cwat_pkg::FRAME_W-1:0] decided_frame_o,
  output logic                         is_candidate_o,
  output logic                         final_decision_o
);

  localparam int unsigned LHS_W = cwat_pkg::DIST_W + CNT_W;
  localparam int unsigned RHS_W = cwat_pkg::CFG_W + SUM_W;
  localparam int unsigned CMP_W = LHS_W + cwat_pkg::FRAC_W;

  logic                         m_valid_q, m_gt_q, m_final_q;
  logic [cwat_pkg::FRAME_W-1:0] m_frame_q;
  logic [LHS_W-1:0]             m_lhs_q;
  logic [RHS_W-1:0]             m_rhs_q;

  logic                         out_valid_q, cand_q, final_q;
  logic [cwat_pkg::FRAME_W-1:0] frame_q;

  logic                         o_adv, m_adv;
  logic [cwat_pkg::DIST_W-1:0]  diff;
  logic [CMP_W-1:0]             lhs_ext, rhs_ext;

  assign o_adv     = ~out_valid_q | ~out_stall_i;
  assign m_adv     = ~m_valid_q | o_adv;
  assign job_pop_o = job_valid_i & m_adv;

  // Only meaningful when the distance is above the static offset.
  assign diff = job_dist_i - cfg_i.static_thr;

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      m_gt_q    <= (job_dist_i > cfg_i.static_thr);
      m_lhs_q   <= LHS_W'(diff) * LHS_W'(job_count_i);
      m_rhs_q   <= RHS_W'(cfg_i.mean_gain) * RHS_W'(job_sum_i);
      m_frame_q <= job_frame_i;
      m_final_q <= job_final_i;
    end
  end

  assign lhs_ext = {m_lhs_q, cwat_pkg::FRAC_W'(0)};
  assign rhs_ext = CMP_W'(m_rhs_q);

  always_ff @(posedge clk_i) begin
    if (o_adv && m_valid_q) begin
      frame_q <= m_frame_q;
      cand_q  <= m_gt_q & (lhs_ext > rhs_ext);
      final_q <= m_final_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (m_adv) begin
        m_valid_q <= job_valid_i;
      end
      if (o_adv) begin
        out_valid_q <= m_valid_q;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign decided_frame_o  = frame_q;
  assign is_candidate_o   = cand_q;
  assign final_decision_o = final_q;

endmodule
